// ----- rtl/osau_pkg.sv -----
// shared types and constants of the operand stack arithmetic unit
`default_nettype none

package osau_pkg;

	localparam int DATA_W              = 32;
	localparam int COUNT_W             = 7;
	localparam int ERR_W               = 2;
	localparam int ACT_W               = 3;
	localparam int OUT_TDATA_W         = 48;
	localparam int DEFAULT_STACK_DEPTH = 64;

	typedef enum logic [ACT_W-1:0] {
		ACT_NOP  = 3'd0,
		ACT_PUSH = 3'd1,
		ACT_SWAP = 3'd2,
		ACT_ADD  = 3'd3,
		ACT_SUB  = 3'd4,
		ACT_DIV  = 3'd5
	} act_t;

	typedef enum logic [ERR_W-1:0] {
		ERR_OK      = 2'd0,
		ERR_FEW     = 2'd1,
		ERR_DIVZERO = 2'd2,
		ERR_FULL    = 2'd3
	} err_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_RESULT
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/osau_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module osau_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/osau_div.sv -----
// iterative signed divider, one quotient bit per cycle, truncating toward zero
`default_nettype none

module osau_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [osau_pkg::DATA_W-1:0]  dividend,
	input  wire logic [osau_pkg::DATA_W-1:0]  divisor,
	output logic                              done,
	output logic      [osau_pkg::DATA_W-1:0]  quotient
);

	localparam int W  = osau_pkg::DATA_W;
	localparam int CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic          neg_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  den_q;
	logic [W-1:0]  rem_sh;
	logic [W:0]    diff;
	logic [W-1:0]  mag_num;
	logic [W-1:0]  mag_den;

	assign mag_num = dividend[W-1] ? (W'(0) - dividend) : dividend;
	assign mag_den = divisor[W-1] ? (W'(0) - divisor) : divisor;
	assign rem_sh  = {rem_q[W-2:0], quo_q[W-1]};
	assign diff    = {1'b0, rem_sh} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[W-1] ^ divisor[W-1];
			quo_q <= mag_num;
			rem_q <= '0;
			den_q <= mag_den;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? (W'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

// ----- rtl/operand_stack_arith_unit.sv -----
// operand stack arithmetic unit top level
// nop, push, swap, add and subtract go from the exec state straight to the result state, which registers the result
// divide waits in the div state for the one bit per cycle divider over 32 quotient bits
// one item at a time: the next input transfer is taken only once the result is registered
// a finished result waits in the output register while the next item is taken
// arst_n clears the stack count, the sequencer and the output valid; stack memory is not cleared
`default_nettype none

module operand_stack_arith_unit #(
	parameter int STACK_DEPTH = osau_pkg::DEFAULT_STACK_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  wire logic [osau_pkg::DATA_W-1:0]      s_axis_tdata,  // push_value
	input  wire logic [osau_pkg::ACT_W-1:0]       s_axis_tuser,  // action
	output logic                                  m_axis_tvalid,
	input  wire logic                             m_axis_tready,
	output logic      [osau_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // top_value, stack_count, error_code
);

	localparam int W  = osau_pkg::DATA_W;
	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int PAD_W = osau_pkg::OUT_TDATA_W - W - osau_pkg::COUNT_W - osau_pkg::ERR_W;

	osau_pkg::state_t             state_q, state_d;
	logic [osau_pkg::ACT_W-1:0]   act_q;
	logic [W-1:0]                 pval_q;
	logic [W-1:0]                 top_q, top_d;
	logic [CW-1:0]                count_q, count_d;
	osau_pkg::err_t               err_q, err_d;
	logic                         out_valid_q;
	logic [osau_pkg::OUT_TDATA_W-1:0] out_data_q;

	logic                         accept;
	logic [CW-1:0]                cnt_m1;
	logic [CW-1:0]                cnt_m2;
	logic                         ram_we;
	logic [AW-1:0]                ram_waddr;
	logic [W-1:0]                 ram_wdata;
	logic [W-1:0]                 ram_rdata;
	logic                         div_start;
	logic                         div_done;
	logic [W-1:0]                 div_quo;
	logic                         load_out;
	logic [W-1:0]                 out_top;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == osau_pkg::ST_IDLE);
	assign cnt_m1        = count_q - CW'(1);
	assign cnt_m2        = count_q - CW'(2);

	osau_ram #(
		.WIDTH (W),
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (accept),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (ram_rdata)
	);

	osau_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (ram_rdata),
		.divisor  (top_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osau_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		top_d     = top_q;
		count_d   = count_q;
		err_d     = err_q;
		ram_we    = 1'b0;
		ram_waddr = cnt_m1[AW-1:0];
		ram_wdata = top_q;
		div_start = 1'b0;
		load_out  = 1'b0;
		case (state_q)
			osau_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = osau_pkg::ST_EXEC;
				end
			end
			osau_pkg::ST_EXEC: begin
				err_d   = osau_pkg::ERR_OK;
				state_d = osau_pkg::ST_RESULT;
				case (act_q)
					osau_pkg::ACT_PUSH: begin
						if (count_q == CW'(STACK_DEPTH)) begin
							err_d = osau_pkg::ERR_FULL;
						end else begin
							ram_we  = (count_q != '0);
							top_d   = pval_q;
							count_d = count_q + CW'(1);
						end
					end
					osau_pkg::ACT_SWAP, osau_pkg::ACT_ADD,
					osau_pkg::ACT_SUB, osau_pkg::ACT_DIV: begin
						if (count_q < CW'(2)) begin
							err_d = osau_pkg::ERR_FEW;
						end else begin
							case (act_q)
								osau_pkg::ACT_SWAP: begin
									ram_we    = 1'b1;
									ram_waddr = cnt_m2[AW-1:0];
									top_d     = ram_rdata;
								end
								osau_pkg::ACT_ADD: begin
									top_d   = ram_rdata + top_q;
									count_d = cnt_m1;
								end
								osau_pkg::ACT_SUB: begin
									top_d   = ram_rdata - top_q;
									count_d = cnt_m1;
								end
								default: begin
									if (top_q == '0) begin
										err_d = osau_pkg::ERR_DIVZERO;
									end else begin
										div_start = 1'b1;
										state_d   = osau_pkg::ST_DIV;
									end
								end
							endcase
						end
					end
					default: begin
					end
				endcase
			end
			osau_pkg::ST_DIV: begin
				if (div_done) begin
					top_d   = div_quo;
					count_d = cnt_m1;
					state_d = osau_pkg::ST_RESULT;
				end
			end
			osau_pkg::ST_RESULT: begin
				if (!out_valid_q || m_axis_tready) begin
					load_out = 1'b1;
					state_d  = osau_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = osau_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_top = (count_q != '0) ? top_q : '0;

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q  <= s_axis_tuser;
			pval_q <= s_axis_tdata;
		end
		top_q <= top_d;
		err_q <= err_d;
		if (load_out) begin
			out_data_q <= {PAD_W'(0), err_q, osau_pkg::COUNT_W'(count_q), out_top};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// ----- rtl/osau_checker.sv -----
// port level checks of the operand stack arithmetic unit and their bind
`default_nettype none

module osau_checker #(
	parameter int STACK_DEPTH = osau_pkg::DEFAULT_STACK_DEPTH
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [osau_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	logic [osau_pkg::DATA_W-1:0]  out_top;
	logic [osau_pkg::COUNT_W-1:0] out_count;
	logic [osau_pkg::ERR_W-1:0]   out_err;

	assign out_top   = m_axis_tdata[31:0];
	assign out_count = m_axis_tdata[38:32];
	assign out_err   = m_axis_tdata[40:39];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in work");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_err == osau_pkg::ERR_FULL
		|-> out_count == osau_pkg::COUNT_W'(STACK_DEPTH))
		else $error("stack full reported below depth");

	a_few_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_err == osau_pkg::ERR_FEW |-> out_count < 7'd2)
		else $error("too few operands reported with two or more entries");

	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && out_count == '0 && STACK_DEPTH < 128 |-> out_top == '0)
		else $error("nonzero top on empty stack");

endmodule

bind operand_stack_arith_unit osau_checker #(
	.STACK_DEPTH (STACK_DEPTH)
) u_osau_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// ----- tb/sv/operand_stack_arith_unit_tb.sv -----
// testbench of the operand stack arithmetic unit: directed table, then random checked operations
`timescale 1ns / 100ps

module operand_stack_arith_unit_tb;

	localparam int STACK_DEPTH  = osau_pkg::DEFAULT_STACK_DEPTH;
	localparam int RANDOM_OPS   = 1050;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 40;
	localparam int PROBE_ROWS   = 23;
	localparam int ACT_W        = osau_pkg::ACT_W;
	localparam int DATA_W       = osau_pkg::DATA_W;
	localparam int COUNT_W      = osau_pkg::COUNT_W;

	localparam logic [ACT_W-1:0]  ACT_SPARE6 = 3'd6;
	localparam logic [ACT_W-1:0]  ACT_SPARE7 = 3'd7;
	localparam logic [DATA_W-1:0] WORD_MAX   = 32'h7fff_ffff;
	localparam logic [DATA_W-1:0] WORD_MIN   = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_ONES  = 32'hffff_ffff;

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN} rx_mode_t;

	typedef struct {
		logic [DATA_W-1:0]  top;
		logic [COUNT_W-1:0] depth;
		osau_pkg::err_t     code;
	} stack_result_t;

	typedef struct {
		logic [ACT_W-1:0]   act;
		logic [DATA_W-1:0]  value;
		bit                 typed;
		logic [DATA_W-1:0]  top;
		logic [COUNT_W-1:0] depth;
		osau_pkg::err_t     code;
	} probe_row_t;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             s_axis_tvalid = 1'b0;
	logic                             s_axis_tready;
	logic [DATA_W-1:0]                s_axis_tdata = '0;   // push_value
	logic [ACT_W-1:0]                 s_axis_tuser = '0;   // action
	logic                             m_axis_tvalid;
	logic                             m_axis_tready = 1'b0;
	logic [osau_pkg::OUT_TDATA_W-1:0] m_axis_tdata;        // top_value, stack_count, error_code

	stack_result_t   stack_result_q[$];
	logic [DATA_W-1:0] model_words[STACK_DEPTH];
	int unsigned     model_depth = 0;
	int unsigned     err_total = 0;
	int unsigned     cycle_count = 0;
	int unsigned     fill_left = 0;

	rx_mode_t        rx_mode = RX_OPEN;
	int unsigned     rx_hold = 0;
	logic [15:0]     rx_pat = 16'h0001;

	probe_row_t probe_rows[PROBE_ROWS] = '{
		'{osau_pkg::ACT_ADD,  32'h0,         1'b1, 32'h0,     7'd0, osau_pkg::ERR_FEW},
		'{osau_pkg::ACT_NOP,  32'h0,         1'b1, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_DIV,  32'h0,         1'b1, 32'h0,     7'd0, osau_pkg::ERR_FEW},
		'{osau_pkg::ACT_PUSH, WORD_MAX,      1'b1, WORD_MAX,  7'd1, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_SWAP, 32'h0,         1'b1, WORD_MAX,  7'd1, osau_pkg::ERR_FEW},
		'{osau_pkg::ACT_PUSH, 32'h1,         1'b1, 32'h1,     7'd2, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_ADD,  32'h0,         1'b1, WORD_MIN,  7'd1, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_PUSH, WORD_ONES,     1'b1, WORD_ONES, 7'd2, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_DIV,  32'h0,         1'b1, WORD_MIN,  7'd1, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_PUSH, 32'h0,         1'b1, 32'h0,     7'd2, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_DIV,  32'h0,         1'b1, 32'h0,     7'd2, osau_pkg::ERR_DIVZERO},
		'{ACT_SPARE6,         32'ha5a5_a5a5, 1'b1, 32'h0,     7'd2, osau_pkg::ERR_OK},
		'{ACT_SPARE7,         32'h5a5a_5a5a, 1'b1, 32'h0,     7'd2, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_SUB,  32'h0,         1'b1, WORD_MIN,  7'd1, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_PUSH, 32'h7,         1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_SWAP, 32'h0,         1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_PUSH, 32'hffff_fff9, 1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_SUB,  32'h0,         1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_PUSH, 32'h3,         1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_DIV,  32'h0,         1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_PUSH, 32'h1234_5678, 1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_SWAP, 32'h0,         1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK},
		'{osau_pkg::ACT_DIV,  32'h0,         1'b0, 32'h0,     7'd0, osau_pkg::ERR_OK}
	};

	operand_stack_arith_unit #(
		.STACK_DEPTH(STACK_DEPTH)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [DATA_W-1:0] word_magnitude(logic [DATA_W-1:0] w);
		return w[DATA_W-1] ? (~w + 1'b1) : w;
	endfunction

	function automatic logic [DATA_W-1:0] divide_toward_zero(logic [DATA_W-1:0] num,
			logic [DATA_W-1:0] den);
		logic [DATA_W-1:0] q;
		q = word_magnitude(num) / word_magnitude(den);
		return (num[DATA_W-1] ^ den[DATA_W-1]) ? (~q + 1'b1) : q;
	endfunction

	// applies one operation to the shadow stack and returns the resulting view of it
	function automatic stack_result_t stack_apply(logic [ACT_W-1:0] act,
			logic [DATA_W-1:0] value);
		stack_result_t res;
		logic [DATA_W-1:0] top_w;
		logic [DATA_W-1:0] sec_w;
		res.code = osau_pkg::ERR_OK;
		case (act)
			osau_pkg::ACT_PUSH: begin
				if (model_depth >= STACK_DEPTH) begin
					res.code = osau_pkg::ERR_FULL;
				end else begin
					model_words[model_depth] = value;
					model_depth++;
				end
			end
			osau_pkg::ACT_SWAP, osau_pkg::ACT_ADD, osau_pkg::ACT_SUB, osau_pkg::ACT_DIV: begin
				if (model_depth < 2) begin
					res.code = osau_pkg::ERR_FEW;
				end else begin
					top_w = model_words[model_depth-1];
					sec_w = model_words[model_depth-2];
					if (act == osau_pkg::ACT_SWAP) begin
						model_words[model_depth-1] = sec_w;
						model_words[model_depth-2] = top_w;
					end else if (act == osau_pkg::ACT_DIV && top_w == '0) begin
						res.code = osau_pkg::ERR_DIVZERO;
					end else begin
						if (act == osau_pkg::ACT_ADD)
							model_words[model_depth-2] = sec_w + top_w;
						else if (act == osau_pkg::ACT_SUB)
							model_words[model_depth-2] = sec_w - top_w;
						else
							model_words[model_depth-2] = divide_toward_zero(sec_w, top_w);
						model_depth--;
					end
				end
			end
			default: ;
		endcase
		res.top = (model_depth > 0) ? model_words[model_depth-1] : '0;
		res.depth = model_depth[COUNT_W-1:0];
		return res;
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 2) begin
			case ($urandom_range(0, 4))
				0: return WORD_MAX;
				1: return WORD_MIN;
				2: return WORD_ONES;
				3: return 32'h1;
				default: return 32'h0;
			endcase
		end else if (r < 5) begin
			return DATA_W'($urandom_range(0, 8)) - 32'd4;
		end
		return $urandom;
	endfunction

	function automatic logic [ACT_W-1:0] pick_action();
		int unsigned r;
		if (fill_left > 0) begin
			fill_left--;
			return osau_pkg::ACT_PUSH;
		end
		r = $urandom_range(0, 99);
		if (r < 2) begin
			// run the stack up to full and push a few more into it
			fill_left = STACK_DEPTH - model_depth + $urandom_range(0, 2);
			return osau_pkg::ACT_PUSH;
		end
		if (r < 6)
			return $urandom_range(0, 2) == 0 ? osau_pkg::ACT_NOP
				: ACT_W'($urandom_range(6, 7));
		if (model_depth < 2)
			return $urandom_range(0, 9) < 8 ? osau_pkg::ACT_PUSH
				: ACT_W'($urandom_range(2, 5));
		if ($urandom_range(0, 9) < 4)
			return osau_pkg::ACT_PUSH;
		return ACT_W'($urandom_range(2, 5));
	endfunction

	// holds one operation on the input until its transfer, then records the expected result
	task automatic send_op(logic [ACT_W-1:0] act, logic [DATA_W-1:0] value, bit typed,
			stack_result_t typed_res);
		stack_result_t res;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= value;
		s_axis_tuser <= act;
		do @(posedge clk); while (!s_axis_tready);
		res = stack_apply(act, value);
		if (typed)
			stack_result_q.push_back(typed_res);
		else
			stack_result_q.push_back(res);
	endtask

	task automatic pace_sender(inout int unsigned burst_left);
		int unsigned gap;
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
				: $urandom_range(1, 12);
		end
	endtask

	always @(posedge clk) begin
		if (rx_hold == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 2));
			rx_hold <= $urandom_range(32, 256);
			rx_pat <= 16'($urandom) | 16'h0001;
		end else begin
			rx_hold <= rx_hold - 1;
			rx_pat <= {rx_pat[0], rx_pat[15:1]};
		end
		case (rx_mode)
			RX_OPEN:  m_axis_tready <= 1'b1;
			RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
			default:  m_axis_tready <= rx_pat[0];
		endcase
	end

	always @(posedge clk) begin
		stack_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (stack_result_q.size() == 0) begin
				$error("result transfer with no result expected: tdata %h", m_axis_tdata);
				err_total++;
			end else begin
				want = stack_result_q.pop_front();
				if (m_axis_tdata[31:0] !== want.top) begin
					$error("top_value expected %h actual %h", want.top, m_axis_tdata[31:0]);
					err_total++;
				end
				if (m_axis_tdata[38:32] !== want.depth) begin
					$error("stack_count expected %0d actual %0d", want.depth,
						m_axis_tdata[38:32]);
					err_total++;
				end
				if (m_axis_tdata[40:39] !== want.code) begin
					$error("error_code expected %0d actual %0d", want.code,
						m_axis_tdata[40:39]);
					err_total++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		stack_result_t typed_res;
		int unsigned burst_left;
		logic [ACT_W-1:0] act;
		burst_left = 8;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (probe_rows[i]) begin
			typed_res.top = probe_rows[i].top;
			typed_res.depth = probe_rows[i].depth;
			typed_res.code = probe_rows[i].code;
			send_op(probe_rows[i].act, probe_rows[i].value, probe_rows[i].typed, typed_res);
			pace_sender(burst_left);
		end
		for (int n = 0; n < RANDOM_OPS; n++) begin
			act = pick_action();
			send_op(act, pick_word(), 1'b0, typed_res);
			pace_sender(burst_left);
		end
		s_axis_tvalid <= 1'b0;
		while (stack_result_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_total == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/osau_pkg.sv
rtl/osau_ram.sv
rtl/osau_div.sv
rtl/operand_stack_arith_unit.sv
rtl/osau_checker.sv
tb/sv/operand_stack_arith_unit_tb.sv
